FILE: design/label_raster_packetizer_assert.svh
// ---------------------------------------------------------------------------
// label_raster_packetizer_assert.svh
// Assertion macros shared by the packetizer checkers.
// ---------------------------------------------------------------------------
`ifndef LABEL_RASTER_PACKETIZER_ASSERT_SVH
`define LABEL_RASTER_PACKETIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("label_raster_packetizer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LRP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("label_raster_packetizer assertion failed");

`endif

FILE: design/lrp_pkg.sv
// ---------------------------------------------------------------------------
// lrp_pkg
// Types and constant byte tables of the label raster packetizer.
// ---------------------------------------------------------------------------
`default_nettype none

package lrp_pkg;

    // Depth of the queue between front and back.
    localparam int QDEPTH = 2;

    // Fixed byte sequences of the printer stream.
    localparam logic [7:0] MAGIC_BYTES [4] = '{8'hFF, 8'hF0, 8'h12, 8'h34};
    localparam logic [7:0] HEAD_FRONT [10] = '{8'h1B, 8'h73, 8'h9A, 8'h02, 8'h00,
                                               8'h00, 8'h1B, 8'h44, 8'h01, 8'h02};
    localparam logic [7:0] HEAD_BACK [4] = '{8'h20, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] TAIL_BYTES [8] = '{8'h1B, 8'h45, 8'h1B, 8'h41,
                                              8'h1B, 8'h51, 8'h12, 8'h34};

    // Low byte of the sum of the four magic bytes.
    localparam logic [7:0] MAGIC_SUM = 8'h35;

    // One classified line as the front hands it to the back.
    typedef struct packed {
        logic [31:0] pix;
        logic        first;
        logic        final_line;
        logic [15:0] count;
        logic [18:0] size;
        logic [7:0]  csum;
    } entry_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

`default_nettype wire

FILE: design/lrp_front.sv
// ---------------------------------------------------------------------------
// lrp_front
// Accepts raster lines, tracks the job position and classifies each line.
// ---------------------------------------------------------------------------
`default_nettype none

module lrp_front
    import lrp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [15:0] line_count,
    input  wire logic        in_valid,
    input  wire logic [31:0] pixel_line,
    input  wire qstat_t      qstat,
    output logic             in_stall,
    output logic             push,
    output entry_t           push_entry
);

    logic [15:0] line_count_reg;
    logic [15:0] lines_done_reg;
    logic [15:0] lines_done_next;
    logic [15:0] count_eff;
    logic        final_line;
    logic [18:0] size;

    // Stall only while the queue has no free slot.
    assign in_stall = qstat.full;
    assign push     = in_valid && !in_stall;

    // Classification of the incoming line.
    always_comb
    begin
        count_eff  = (line_count_reg == 16'd0) ? 16'd1 : line_count_reg;
        final_line = ({1'b0, lines_done_reg} + 17'd1) >= {1'b0, count_eff};
        size       = {1'b0, count_eff, 2'b00} + 19'd24;

        push_entry.pix        = pixel_line;
        push_entry.first      = (lines_done_reg == 16'd0);
        push_entry.final_line = final_line;
        push_entry.count      = count_eff;
        push_entry.size       = size;
        push_entry.csum       = 8'(MAGIC_SUM + size[7:0] + size[15:8] + {5'd0, size[18:16]});

        lines_done_next = final_line ? 16'd0 : lines_done_reg + 16'd1;
    end

    // Configuration register and job position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= 16'd1;
            lines_done_reg <= 16'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                line_count_reg <= line_count;
            end
            if (push)
            begin
                lines_done_reg <= lines_done_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/lrp_queue.sv
// ---------------------------------------------------------------------------
// lrp_queue
// Short first-in first-out queue of classified lines.
// ---------------------------------------------------------------------------
`default_nettype none

module lrp_queue
    import lrp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output entry_t      head,
    output qstat_t      qstat
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    entry_t             slot_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;

    assign head        = slot_reg[rd_ptr_reg];
    assign qstat.full  = (fill_reg == CNT_W'(QDEPTH));
    assign qstat.empty = (fill_reg == '0);

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/lrp_back.sv
// ---------------------------------------------------------------------------
// lrp_back
// Walks the bytes of each queued line, inserts chunk sequence bytes and
// drives the output register one word per cycle while out_stall does not hold it.
// ---------------------------------------------------------------------------
`default_nettype none

module lrp_back
    import lrp_pkg::*;
#(
    parameter int CHUNK_PAYLOAD = 500
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire entry_t head,
    input  wire qstat_t qstat,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_stall,
    output logic [7:0]  out_byte,
    output logic        is_header,
    output logic        chunk_first,
    output logic        write_last,
    output logic        job_last,
    output logic        run_last
);

    localparam int FILL_W = $clog2(CHUNK_PAYLOAD + 1);

    typedef enum logic [1:0] {
        PH_HDR,
        PH_HEAD,
        PH_PIX,
        PH_TAIL
    } phase_t;

    phase_t            phase_reg, phase_next, cur_phase;
    logic [4:0]        idx_reg, idx_next, cur_idx;
    logic              busy_reg, busy_next;
    logic              open_reg, open_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        seq_reg, seq_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              is_header_reg, is_header_next;
    logic              chunk_first_reg, chunk_first_next;
    logic              write_last_reg, write_last_next;
    logic              job_last_reg, job_last_next;
    logic              run_last_reg, run_last_next;

    logic              load_ok;
    logic              go;
    logic [7:0]        data_byte;
    logic              phase_end;
    logic              done;
    logic              wl;
    logic              jl;
    logic [31:0]       size32;
    logic [31:0]       count32;
    logic [4:0]        rel;
    logic [FILL_W-1:0] fill_inc;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign is_header   = is_header_reg;
    assign chunk_first = chunk_first_reg;
    assign write_last  = write_last_reg;
    assign job_last    = job_last_reg;
    assign run_last    = run_last_reg;

    // Byte selection for the current position within the line.
    always_comb
    begin
        cur_phase = busy_reg ? phase_reg : (head.first ? PH_HDR : PH_PIX);
        cur_idx   = busy_reg ? idx_reg : 5'd0;
        size32    = {13'd0, head.size};
        count32   = {16'd0, head.count};
        rel       = 5'd0;
        data_byte = 8'h00;
        phase_end = 1'b0;
        unique case (cur_phase)
            PH_HDR:
            begin
                phase_end = (cur_idx == 5'd8);
                if (cur_idx < 5'd4)
                begin
                    data_byte = MAGIC_BYTES[cur_idx[1:0]];
                end
                else if (cur_idx < 5'd8)
                begin
                    data_byte = size32[8*cur_idx[1:0] +: 8];
                end
                else
                begin
                    data_byte = head.csum;
                end
            end
            PH_HEAD:
            begin
                phase_end = (cur_idx == 5'd17);
                if (cur_idx < 5'd10)
                begin
                    data_byte = HEAD_FRONT[cur_idx[3:0]];
                end
                else if (cur_idx < 5'd14)
                begin
                    rel       = cur_idx - 5'd10;
                    data_byte = count32[8*rel[1:0] +: 8];
                end
                else
                begin
                    rel       = cur_idx - 5'd14;
                    data_byte = HEAD_BACK[rel[1:0]];
                end
            end
            PH_PIX:
            begin
                phase_end = (cur_idx == 5'd3);
                data_byte = head.pix[8*cur_idx[1:0] +: 8];
            end
            PH_TAIL:
            begin
                phase_end = (cur_idx == 5'd7);
                data_byte = TAIL_BYTES[cur_idx[2:0]];
            end
            default:
            begin
                phase_end = 1'b0;
            end
        endcase
    end

    // Sequencer and output register next values.
    always_comb
    begin
        load_ok = !out_valid_reg || !out_stall;
        go      = !qstat.empty && load_ok;

        phase_next       = phase_reg;
        idx_next         = idx_reg;
        busy_next        = busy_reg;
        open_next        = open_reg;
        fill_next        = fill_reg;
        seq_next         = seq_reg;
        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        is_header_next   = is_header_reg;
        chunk_first_next = chunk_first_reg;
        write_last_next  = write_last_reg;
        job_last_next    = job_last_reg;
        run_last_next    = run_last_reg;
        done             = 1'b0;
        wl               = 1'b0;
        jl               = 1'b0;
        fill_inc         = fill_reg + 1'b1;

        if (go)
        begin
            out_valid_next   = 1'b1;
            is_header_next   = 1'b0;
            chunk_first_next = 1'b0;
            write_last_next  = 1'b0;
            job_last_next    = 1'b0;
            run_last_next    = 1'b0;

            if ((cur_phase != PH_HDR) && !open_reg)
            begin
                // A new chunk opens with its sequence word.
                out_byte_next    = seq_reg;
                chunk_first_next = 1'b1;
                open_next        = 1'b1;
                busy_next        = 1'b1;
                phase_next       = cur_phase;
                idx_next         = cur_idx;
            end
            else
            begin
                out_byte_next = data_byte;
                if (cur_phase == PH_HDR)
                begin
                    is_header_next  = 1'b1;
                    write_last_next = phase_end;
                end
                else
                begin
                    // Payload word: count it into the open chunk.
                    jl = (cur_phase == PH_TAIL) && phase_end;
                    wl = (fill_inc == FILL_W'(CHUNK_PAYLOAD)) || jl;
                    write_last_next = wl;
                    job_last_next   = jl;
                    if (wl)
                    begin
                        fill_next = '0;
                        open_next = 1'b0;
                        seq_next  = jl ? 8'd0 : seq_reg + 8'd1;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end

                // Step to the next position of the line.
                busy_next = 1'b1;
                if (!phase_end)
                begin
                    phase_next = cur_phase;
                    idx_next   = cur_idx + 5'd1;
                end
                else
                begin
                    idx_next = 5'd0;
                    unique case (cur_phase)
                        PH_HDR:  phase_next = PH_HEAD;
                        PH_HEAD: phase_next = PH_PIX;
                        PH_PIX:
                        begin
                            if (head.final_line)
                            begin
                                phase_next = PH_TAIL;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        PH_TAIL: done = 1'b1;
                        default: done = 1'b0;
                    endcase
                    if (done)
                    begin
                        busy_next     = 1'b0;
                        run_last_next = 1'b1;
                    end
                end
            end
        end
        else if (load_ok)
        begin
            out_valid_next = 1'b0;
        end

        pop = go && done;
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PIX;
            idx_reg       <= 5'd0;
            busy_reg      <= 1'b0;
            open_reg      <= 1'b0;
            fill_reg      <= '0;
            seq_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            busy_reg      <= busy_next;
            open_reg      <= open_next;
            fill_reg      <= fill_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_byte_reg    <= out_byte_next;
        is_header_reg   <= is_header_next;
        chunk_first_reg <= chunk_first_next;
        write_last_reg  <= write_last_next;
        job_last_reg    <= job_last_next;
        run_last_reg    <= run_last_next;
    end

endmodule

`default_nettype wire

FILE: design/label_raster_packetizer.sv
// ---------------------------------------------------------------------------
// label_raster_packetizer
// Turns 32-pixel raster lines into a chunked label-printer byte stream.
//
//   Channel   Handshake              Payload
//   -------   --------------------   ------------------------------------
//   config    cfg_valid / cfg_ready  line_count
//   input     in_valid / in_stall    pixel_line
//   output    out_valid / out_stall  out_byte, is_header, chunk_first,
//                                    write_last, job_last, run_last
//
// The output register sends one word per cycle while out_stall is low; a line is 4
// words, plus one chunk sequence word for each chunk it opens.
// A job's first line adds 9 header and 18 head words; its final line adds
// 8 tail words.
// A two-entry queue lets new lines be taken while the back end is still
// sending; in_stall rises only while that queue is full.
// Reset sets line_count to 1 and starts a fresh job with sequence 0.
// ---------------------------------------------------------------------------
`default_nettype none

module label_raster_packetizer
    import lrp_pkg::*;
#(
    parameter int CHUNK_PAYLOAD = 500
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] line_count,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] pixel_line,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             is_header,
    output logic             chunk_first,
    output logic             write_last,
    output logic             job_last,
    output logic             run_last
);

    logic   push;
    logic   pop;
    entry_t push_entry;
    entry_t head;
    qstat_t qstat;

    // The configuration register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // Front end: line acceptance and classification.
    lrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .line_count (line_count),
        .in_valid   (in_valid),
        .pixel_line (pixel_line),
        .qstat      (qstat),
        .in_stall   (in_stall),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue between the two halves.
    lrp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    // Back end: byte sequencing and chunking.
    lrp_back #(
        .CHUNK_PAYLOAD (CHUNK_PAYLOAD)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .qstat       (qstat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .is_header   (is_header),
        .chunk_first (chunk_first),
        .write_last  (write_last),
        .job_last    (job_last),
        .run_last    (run_last)
    );

endmodule

`default_nettype wire

FILE: design/lrp_checker.sv
// ---------------------------------------------------------------------------
// lrp_checker
// Port-level checks of the packetizer output stream.
// ---------------------------------------------------------------------------
`default_nettype none

`include "label_raster_packetizer_assert.svh"

module lrp_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] out_byte,
    input  wire logic       is_header,
    input  wire logic       chunk_first,
    input  wire logic       write_last,
    input  wire logic       job_last,
    input  wire logic       run_last
);

    // A stalled word stays put.
    `LRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte))

    // A sequence word never closes a write, a job or a line.
    `LRP_ASSERT_NOW(a_seq_word, clk, rst_n, out_valid && chunk_first, !is_header && !write_last && !job_last && !run_last)

    // The job's final word also closes its chunk and its line.
    `LRP_ASSERT_NOW(a_job_end, clk, rst_n, out_valid && job_last, write_last && run_last && !is_header)

    // Header words never end a line.
    `LRP_ASSERT_NOW(a_header_word, clk, rst_n, out_valid && is_header, !run_last && !chunk_first)

endmodule

bind label_raster_packetizer lrp_checker u_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the label raster packetizer. Raster lines are
// pushed through the input channel while a line predictor works out the
// printer words each accepted line must produce: the header write, the head
// command block, the line bytes, the tail, and the chunk sequence words.
// The monitor compares every output word with the oldest predicted word.
// Both channels idle and stall at random, and the receiver holds off once
// long enough for the block to stall its input.
// ---------------------------------------------------------------------------

module tb_top;

    // Payload bytes per chunk, passed to the block as well.
    localparam int CHUNK_BYTES = 500;

    // Fixed stream bytes, byte 0 in the low bits of each constant.
    localparam logic [31:0] SYNC_MAGIC = 32'h3412_F0FF;
    localparam logic [79:0] HEAD_PRE = 80'h0201_441B_0000_029A_731B;
    localparam logic [31:0] HEAD_POST = 32'h0000_0020;
    localparam logic [63:0] TAIL_SEQ = 64'h3412_511B_411B_451B;

    // Timing of the bench.
    localparam int IDLE_PCT = 28;
    localparam int IDLE_GAP = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int STUCK_LIMIT = 1000;
    localparam int HOLD_AT = 40;
    localparam int HOLD_CYCLES = 80;
    localparam int CALM_FROM = 70;
    localparam int CALM_TO = 130;
    localparam int RANDOM_LINES = 244;
    localparam int REPORT_LIMIT = 10;

    // One word of the printer stream with its marks.
    typedef struct packed {
        logic [7:0] value;
        logic       header;
        logic       seq_mark;
        logic       write_end;
        logic       job_end;
        logic       line_end;
    } stream_word_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] line_count = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] pixel_line = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        is_header;
    logic        chunk_first;
    logic        write_last;
    logic        job_last;
    logic        run_last;

    // Lines waiting to be offered, and words waiting to come out.
    logic [31:0]  pixel_lines_pending[$];
    stream_word_t stream_expected[$];
    stream_word_t line_words[$];

    // Predictor copy of the register and the job state.
    logic [15:0] job_line_limit = 16'd1;
    logic [15:0] lines_in_job = 16'd0;
    int          chunk_fill = 0;
    logic [7:0]  chunk_seq = 8'd0;

    int   fault_count = 0;
    int   lines_taken = 0;
    int   stuck_cycles = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic calm;

    assign calm = (lines_taken >= CALM_FROM) && (lines_taken < CALM_TO);

    label_raster_packetizer #(
        .CHUNK_PAYLOAD(CHUNK_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .line_count(line_count),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pixel_line(pixel_line),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .is_header(is_header),
        .chunk_first(chunk_first),
        .write_last(write_last),
        .job_last(job_last),
        .run_last(run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void add_word(input logic [7:0] value, input logic header,
                                     input logic seq_mark, input logic write_end,
                                     input logic job_end);
        line_words.push_back('{value, header, seq_mark, write_end, job_end, 1'b0});
    endfunction

    // Data stream byte: opens a chunk with its sequence word when needed and
    // closes the chunk when it is full or the job ends.
    function automatic void add_payload(input logic [7:0] value, input logic job_end);
        logic closes;
        if (chunk_fill == 0)
        begin
            add_word(chunk_seq, 1'b0, 1'b1, 1'b0, 1'b0);
        end
        chunk_fill++;
        closes = (chunk_fill >= CHUNK_BYTES) || job_end;
        add_word(value, 1'b0, 1'b0, closes, job_end);
        if (closes)
        begin
            chunk_fill = 0;
            chunk_seq = chunk_seq + 8'd1;
        end
    endfunction

    // Works out every word that one accepted raster line produces.
    function automatic void predict_line(input logic [31:0] pix);
        logic [15:0] count;
        logic [31:0] size;
        logic [7:0]  sum;
        logic        final_line;
        count = (job_line_limit == 16'd0) ? 16'd1 : job_line_limit;
        final_line = (int'(lines_in_job) + 1) >= int'(count);
        line_words.delete();
        if (lines_in_job == 16'd0)
        begin
            // Header write: magic, stream size, and the byte sum of both.
            size = 4 * count + 24;
            sum = 8'd0;
            for (int i = 0; i < 4; i++)
            begin
                add_word(SYNC_MAGIC[8*i +: 8], 1'b1, 1'b0, 1'b0, 1'b0);
                sum = sum + SYNC_MAGIC[8*i +: 8];
            end
            for (int i = 0; i < 4; i++)
            begin
                add_word(size[8*i +: 8], 1'b1, 1'b0, 1'b0, 1'b0);
                sum = sum + size[8*i +: 8];
            end
            add_word(sum, 1'b1, 1'b0, 1'b1, 1'b0);

            // Head command block opens the data stream of a new job.
            chunk_fill = 0;
            chunk_seq = 8'd0;
            for (int i = 0; i < 10; i++)
                add_payload(HEAD_PRE[8*i +: 8], 1'b0);
            for (int i = 0; i < 4; i++)
                add_payload(8'({16'd0, count} >> (8 * i)), 1'b0);
            for (int i = 0; i < 4; i++)
                add_payload(HEAD_POST[8*i +: 8], 1'b0);
        end

        // Pixel bytes, lowest pixel first.
        for (int i = 0; i < 4; i++)
            add_payload(pix[8*i +: 8], 1'b0);

        if (final_line)
        begin
            for (int i = 0; i < 8; i++)
                add_payload(TAIL_SEQ[8*i +: 8], i == 7);
            lines_in_job = 16'd0;
            chunk_fill = 0;
            chunk_seq = 8'd0;
        end
        else
        begin
            lines_in_job = lines_in_job + 16'd1;
        end

        line_words[line_words.size() - 1].line_end = 1'b1;
        foreach (line_words[i])
            stream_expected.push_back(line_words[i]);
    endfunction

    function automatic void report_fault(input string what, input stream_word_t want,
                                         input stream_word_t seen);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
        begin
            $display("%s: expected %02h h%b s%b w%b j%b r%b, got %02h h%b s%b w%b j%b r%b",
                     what, want.value, want.header, want.seq_mark, want.write_end,
                     want.job_end, want.line_end, seen.value, seen.header, seen.seq_mark,
                     seen.write_end, seen.job_end, seen.line_end);
        end
    endfunction

    // Appends n raster lines with a mix of plain and random pixel patterns.
    function automatic void queue_lines(input int n);
        logic [31:0] pix;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(7))
                0: pix = 32'h0000_0000;
                1: pix = 32'hFFFF_FFFF;
                2: pix = 32'h1 << $urandom_range(31);
                default: pix = $urandom;
            endcase
            pixel_lines_pending.push_back(pix);
        end
    endfunction

    // Register writes only happen with nothing in flight.
    task automatic set_line_count(input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        line_count <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        job_line_limit = value;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (pixel_lines_pending.size() != 0 || in_valid || stream_expected.size() != 0);
        repeat (IDLE_GAP) @(negedge clk);
    endtask

    // Sender: offers the next line, at random outside the calm stretch, once the current line is taken.
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (pixel_lines_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                in_valid <= 1'b1;
                pixel_line <= pixel_lines_pending.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a calm stretch.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && lines_taken >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Monitor: predicts on each accepted line, checks each accepted word.
    always @(posedge clk)
    begin : monitor
        stream_word_t seen;
        stream_word_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_line(pixel_line);
                lines_taken <= lines_taken + 1;
            end
            if (out_valid && !out_stall)
            begin
                seen = '{out_byte, is_header, chunk_first, write_last, job_last, run_last};
                if (stream_expected.size() == 0)
                begin
                    report_fault("unexpected word", '0, seen);
                end
                else
                begin
                    want = stream_expected.pop_front();
                    if (seen !== want)
                        report_fault("word mismatch", want, seen);
                end
            end
        end
    end

    // Count cycles in which no channel moves anything.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin : watchdog
        do @(posedge clk); while (stuck_cycles < STUCK_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int random_lines;
        int job_len;
        int lead;
        int shrink;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // One-line job on the count left by reset.
        pixel_lines_pending.push_back(32'h0000_0000);
        wait_idle();

        set_line_count(16'd2);
        pixel_lines_pending.push_back(32'hFFFF_FFFF);
        pixel_lines_pending.push_back(32'h8000_0001);
        wait_idle();

        // A zero count behaves as a count of one.
        set_line_count(16'd0);
        pixel_lines_pending.push_back(32'hA5C3_0F81);
        wait_idle();

        // Largest count in the header, then cut short by a later write.
        set_line_count(16'hFFFF);
        pixel_lines_pending.push_back(32'h5555_AAAA);
        pixel_lines_pending.push_back(32'hAAAA_5555);
        wait_idle();
        set_line_count(16'd1);
        pixel_lines_pending.push_back(32'hDEAD_BEEF);
        wait_idle();

        // Count raised mid-job: the head block keeps the first count.
        set_line_count(16'd3);
        pixel_lines_pending.push_back(32'h0F0F_0F0F);
        wait_idle();
        set_line_count(16'd5);
        pixel_lines_pending.push_back(32'h0000_0001);
        pixel_lines_pending.push_back(32'h8000_0000);
        pixel_lines_pending.push_back(32'h0000_FF00);
        pixel_lines_pending.push_back(32'h7FFF_FFFE);
        wait_idle();

        // Long job that crosses a chunk boundary; hold-off lands inside it.
        set_line_count(16'd130);
        queue_lines(130);
        wait_idle();
        random_lines = 130;

        while (random_lines < RANDOM_LINES)
        begin
            if ($urandom_range(3) == 0)
            begin
                // Start with a large count, then shrink it part way through.
                set_line_count(16'($urandom_range(65535, 9)));
                lead = $urandom_range(4, 1);
                queue_lines(lead);
                wait_idle();
                shrink = $urandom_range(lead + 4, 1);
                set_line_count(16'(shrink));
                job_len = (shrink > lead) ? shrink - lead : 1;
                queue_lines(job_len);
                random_lines += lead + job_len;
            end
            else
            begin
                job_len = $urandom_range(8, 0);
                set_line_count(16'(job_len));
                job_len = (job_len == 0) ? 1 : job_len;
                queue_lines(job_len);
                random_lines += job_len;
            end
            wait_idle();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fault_count == 0 && stream_expected.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
